### rtl/qmjs_pkg.sv
// shared constants and types for the quintic minimum-jerk solver
// no dependencies; used by qmjs_div and quintic_min_jerk_solver_unit
package qmjs_pkg;

   localparam int IN_W          = 32;
   localparam int T_W           = 24;
   localparam int COEF_W        = 64;
   localparam int IN_FRAC_DEF   = 16;
   localparam int OUT_FRAC_DEF  = 40;

   // setup register, one register per quotient bit, sign and clip register
   localparam int DIV_LAT       = COEF_W + 2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic signed [COEF_W-1:0] c0;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c2;
      logic                     sat;
      logic                     zero;
   } side_type;

endpackage

### rtl/qmjs_div.sv
// pipelined restoring divider: round(num * 2^PW / (den / 2)), half away from zero,
// clipped to a signed 64-bit coefficient; one quotient bit per stage
// depends on qmjs_pkg
module qmjs_div #(
   parameter int NUM_W = 90,
   parameter int DEN_W = 74,
   parameter int PW    = 40
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [NUM_W-1:0]              num,
   input  logic        [DEN_W-1:0]              den,
   output logic signed [qmjs_pkg::COEF_W-1:0]   coef,
   output logic                                 sat
);

   localparam int QW = qmjs_pkg::COEF_W;
   localparam int WC = ((NUM_W + 1 + PW > DEN_W + QW) ? NUM_W + 1 + PW : DEN_W + QW) + 1;

   logic [WC-1:0]    rem_ff [0:QW-1];
   logic [DEN_W-1:0] den_ff [0:QW-1];
   logic [QW-1:0]    q_ff   [0:QW];
   logic [QW:0]      neg_ff;
   logic [QW:0]      ovf_ff;

   logic [NUM_W-1:0] mag;
   logic [WC-1:0]    m_in;
   logic             ovf_in;

   // numerator 2|n|2^PW + den/2 over divisor den gives the rounded magnitude
   always_comb begin
      mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      m_in   = (WC'(mag) << (PW + 1)) + (WC'(den) >> 1);
      ovf_in = m_in >= (WC'(den) << QW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= m_in;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[NUM_W-1];
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      localparam int B = QW - j;
      logic [WC-1:0] sub;
      logic          ge;
      logic [QW-1:0] q_in;

      always_comb begin
         sub     = WC'(den_ff[j-1]) << B;
         ge      = rem_ff[j-1] >= sub;
         q_in    = q_ff[j-1];
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j]   <= q_in;
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end

      if (j < QW) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge ? rem_ff[j-1] - sub : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   logic [QW-1:0]        q_fin;
   logic                 neg_fin;
   logic                 sat_in;
   logic signed [QW-1:0] coef_in;
   logic signed [QW-1:0] coef_ff;
   logic                 sat_ff;

   // negative side may reach 2^63, positive side stops at 2^63 - 1
   always_comb begin
      q_fin   = q_ff[QW];
      neg_fin = neg_ff[QW];
      sat_in  = ovf_ff[QW] || (q_fin[QW-1] && (!neg_fin || (q_fin[QW-2:0] != '0)));
      if (sat_in) begin
         coef_in = neg_fin ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
         coef_in = neg_fin ? -$signed(q_fin) : $signed(q_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coef_ff <= coef_in;
         sat_ff  <= sat_in;
      end
   end

   assign coef = coef_ff;
   assign sat  = sat_ff;

endmodule

### rtl/quintic_min_jerk_solver_unit.sv
// throughput: one request per cycle while req_stall is low; seven multiply/add stages feed three
//   64-stage restoring dividers (one quotient bit per stage) for coef_3..coef_5
// reset: synchronous, clears the stage valid bits and the response valid only
// depends on qmjs_pkg and qmjs_div
module quintic_min_jerk_solver_unit #(
   parameter int IN_FRAC_BITS  = qmjs_pkg::IN_FRAC_DEF,
   parameter int OUT_FRAC_BITS = qmjs_pkg::OUT_FRAC_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_start_pos,
   input  logic signed [31:0]  req_start_vel,
   input  logic signed [31:0]  req_start_acc,
   input  logic signed [31:0]  req_end_pos,
   input  logic signed [31:0]  req_end_vel,
   input  logic signed [31:0]  req_end_acc,
   input  logic        [23:0]  req_duration,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [63:0]  rsp_coef_0,
   output logic signed [63:0]  rsp_coef_1,
   output logic signed [63:0]  rsp_coef_2,
   output logic signed [63:0]  rsp_coef_3,
   output logic signed [63:0]  rsp_coef_4,
   output logic signed [63:0]  rsp_coef_5,
   output logic        [1:0]   rsp_status
);

   localparam int F    = IN_FRAC_BITS;
   localparam int O    = OUT_FRAC_BITS;
   localparam int SH   = O - F;
   localparam int SHA  = (SH > 0) ? SH - 1 : 0;
   localparam int WX   = (34 + SH > 66) ? 34 + SH : 66;
   localparam int W_DN = ((33 + F > 56) ? 33 + F : 56) + 1;
   localparam int W_DH = W_DN - 7;
   localparam int W_DT = W_DN + 25;
   localparam int W_H0 = (34 + 2 * F > 57 + F) ? 34 + 2 * F : 57 + F;
   localparam int W_HN = ((W_H0 > 81) ? W_H0 : 81) + 2;
   localparam int W_N  = ((W_HN > W_DT) ? W_HN : W_DT) + 6;
   localparam int NV   = 8 + qmjs_pkg::DIV_LAT;

   localparam logic signed [WX-1:0] MAXX = WX'(64'sh7FFF_FFFF_FFFF_FFFF);
   localparam logic signed [WX-1:0] MINX = WX'(64'sh8000_0000_0000_0000);

   function automatic logic [64:0] clip64(input logic signed [WX-1:0] v);
      logic [64:0] r;
      if (v > MAXX) begin
         r = {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
      end else if (v < MINX) begin
         r = {1'b1, 64'h8000_0000_0000_0000};
      end else begin
         r = {1'b0, v[63:0]};
      end
      return r;
   endfunction

   // ---------------- flow control ----------------
   logic          out_load;
   logic          pipe_en;
   logic          last_vld;
   logic [NV-1:0] vld_ff, vld_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign last_vld  = vld_ff[NV-1];
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign pipe_en   = out_load || !last_vld;
   assign req_stall = !pipe_en;
   assign vld_in    = {vld_ff[NV-2:0], req_valid};
   assign rsp_valid_in = out_load ? last_vld : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            vld_ff <= vld_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- input registers ----------------
   logic signed [31:0] in_x0_ff, in_v0_ff, in_a0_ff, in_x1_ff, in_v1_ff, in_a1_ff;
   logic        [23:0] in_t_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         in_x0_ff <= req_start_pos;
         in_v0_ff <= req_start_vel;
         in_a0_ff <= req_start_acc;
         in_x1_ff <= req_end_pos;
         in_v1_ff <= req_end_vel;
         in_a1_ff <= req_end_acc;
         in_t_ff  <= req_duration;
      end
   end

   // ---------------- stage a: first products, low coefficients ----------------
   logic signed [32:0] a_dx_in, a_dv_in, a_dx_ff, a_dv_ff;
   logic signed [55:0] a_pv0t_in, a_pa0t_in, a_pv0t_ff, a_pa0t_ff;
   logic signed [56:0] a_pdat_in, a_pdat_ff;
   logic        [47:0] a_t2_in, a_t2_ff;
   logic        [23:0] a_t_ff;
   qmjs_pkg::side_type side_in;

   logic signed [32:0]   a_ext;
   logic        [32:0]   a_mag, a_half;
   logic signed [WX-1:0] a_rnd, a_sh;
   logic [64:0]          k0, k1, k2;

   always_comb begin
      a_dx_in   = 33'(in_x1_ff) - 33'(in_x0_ff);
      a_dv_in   = 33'(in_v1_ff) - 33'(in_v0_ff);
      a_pv0t_in = in_v0_ff * $signed({1'b0, in_t_ff});
      a_pa0t_in = in_a0_ff * $signed({1'b0, in_t_ff});
      a_pdat_in = (33'(in_a1_ff) - 33'(in_a0_ff)) * $signed({1'b0, in_t_ff});
      a_t2_in   = 48'(in_t_ff) * 48'(in_t_ff);

      // half the start acceleration, rounded away from zero when no shift is left
      a_ext  = 33'(in_a0_ff);
      a_mag  = a_ext[32] ? 33'(-a_ext) : 33'(a_ext);
      a_half = (a_mag + 33'd1) >> 1;
      a_rnd  = a_ext[32] ? -WX'($signed({1'b0, a_half})) : WX'($signed({1'b0, a_half}));
      a_sh   = WX'(in_a0_ff) <<< SHA;

      k0 = clip64(WX'(in_x0_ff) <<< SH);
      k1 = clip64(WX'(in_v0_ff) <<< SH);
      k2 = clip64((SH == 0) ? a_rnd : a_sh);

      side_in.c0   = $signed(k0[63:0]);
      side_in.c1   = $signed(k1[63:0]);
      side_in.c2   = $signed(k2[63:0]);
      side_in.sat  = k0[64] | k1[64] | k2[64];
      side_in.zero = in_t_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_dx_ff   <= a_dx_in;
         a_dv_ff   <= a_dv_in;
         a_pv0t_ff <= a_pv0t_in;
         a_pa0t_ff <= a_pa0t_in;
         a_pdat_ff <= a_pdat_in;
         a_t2_ff   <= a_t2_in;
         a_t_ff    <= in_t_ff;
      end
   end

   // ---------------- stage b: partial products by T ----------------
   logic signed [32:0]     b_dx_ff;
   logic signed [55:0]     b_pv0t_ff;
   logic        [23:0]     b_t_ff;
   logic signed [W_DN-1:0] b_dn_in, b_dn_ff;
   logic signed [48:0]     b_p3h_in, b_p3h_ff;
   logic        [55:0]     b_p3l_in, b_p3l_ff;
   logic signed [49:0]     b_dah_in, b_dah_ff;
   logic        [55:0]     b_dal_in, b_dal_ff;
   logic        [39:0]     b_t3h_in, b_t3h_ff;
   logic        [55:0]     b_t3l_in, b_t3l_ff;

   always_comb begin
      b_dn_in  = (W_DN'(a_dv_ff) <<< F) - W_DN'(a_pa0t_ff);
      b_p3h_in = $signed(a_pa0t_ff[55:32]) * $signed({1'b0, a_t_ff});
      b_p3l_in = 56'(a_pa0t_ff[31:0]) * 56'(a_t_ff);
      b_dah_in = $signed(a_pdat_ff[56:32]) * $signed({1'b0, a_t_ff});
      b_dal_in = 56'(a_pdat_ff[31:0]) * 56'(a_t_ff);
      b_t3h_in = 40'(a_t2_ff[47:32]) * 40'(a_t_ff);
      b_t3l_in = 56'(a_t2_ff[31:0]) * 56'(a_t_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_dx_ff   <= a_dx_ff;
         b_pv0t_ff <= a_pv0t_ff;
         b_t_ff    <= a_t_ff;
         b_dn_ff   <= b_dn_in;
         b_p3h_ff  <= b_p3h_in;
         b_p3l_ff  <= b_p3l_in;
         b_dah_ff  <= b_dah_in;
         b_dal_ff  <= b_dal_in;
         b_t3h_ff  <= b_t3h_in;
         b_t3l_ff  <= b_t3l_in;
      end
   end

   // ---------------- stage c: hn = 2 s^3 h, da2, T^3 ----------------
   logic signed [W_HN-1:0] c_hn_in, c_hn_ff, c_p3;
   logic signed [81:0]     c_da2_in, c_da2_ff;
   logic        [71:0]     c_t3_in, c_t3_ff;
   logic        [23:0]     c_t_ff;
   logic signed [W_DH-1:0] c_dth_in, c_dth_ff;
   logic        [55:0]     c_dtl_in, c_dtl_ff;

   always_comb begin
      c_p3     = (W_HN'(b_p3h_ff) <<< 32) + W_HN'($signed({1'b0, b_p3l_ff}));
      c_hn_in  = (W_HN'(b_dx_ff) <<< (2 * F + 1)) - (W_HN'(b_pv0t_ff) <<< (F + 1)) - c_p3;
      c_da2_in = (82'(b_dah_ff) <<< 32) + 82'($signed({1'b0, b_dal_ff}));
      c_t3_in  = {b_t3h_ff, 32'd0} + 72'(b_t3l_ff);
      c_dth_in = $signed(b_dn_ff[W_DN-1:32]) * $signed({1'b0, b_t_ff});
      c_dtl_in = 56'(b_dn_ff[31:0]) * 56'(b_t_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         c_hn_ff  <= c_hn_in;
         c_da2_ff <= c_da2_in;
         c_t3_ff  <= c_t3_in;
         c_t_ff   <= b_t_ff;
         c_dth_ff <= c_dth_in;
         c_dtl_ff <= c_dtl_in;
      end
   end

   // ---------------- stage d: dt = s^2 dv T, T^4 partial products ----------------
   logic signed [W_HN-1:0] d_hn_ff;
   logic signed [81:0]     d_da2_ff;
   logic        [71:0]     d_t3_ff;
   logic        [23:0]     d_t_ff;
   logic signed [W_DT-1:0] d_dt_in, d_dt_ff;
   logic        [95:0]     d_t3x;
   logic        [55:0]     d_t4pp_in [0:2];
   logic        [55:0]     d_t4pp_ff [0:2];

   always_comb begin
      d_dt_in = (W_DT'(c_dth_ff) <<< 32) + W_DT'($signed({1'b0, c_dtl_ff}));
      d_t3x   = 96'(c_t3_ff);
      for (int k = 0; k < 3; k++) begin
         d_t4pp_in[k] = 56'(d_t3x[32*k +: 32]) * 56'(c_t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d_hn_ff   <= c_hn_ff;
         d_da2_ff  <= c_da2_ff;
         d_t3_ff   <= c_t3_ff;
         d_t_ff    <= c_t_ff;
         d_dt_ff   <= d_dt_in;
         d_t4pp_ff <= d_t4pp_in;
      end
   end

   // ---------------- stage e: numerators, T^4 ----------------
   logic signed [W_N-1:0] e_n3_in, e_n4_in, e_n5_in, e_n3_ff, e_n4_ff, e_n5_ff;
   logic signed [W_N-1:0] e_h, e_d, e_a;
   logic        [95:0]    e_t4_in, e_t4_ff;
   logic        [71:0]    e_t3_ff;
   logic        [23:0]    e_t_ff;

   always_comb begin
      e_h = W_N'(d_hn_ff);
      e_d = W_N'(d_dt_ff);
      e_a = W_N'(d_da2_ff);
      // 10h - 8dt + da2, 14dt - 15h - 2da2, 6h - 6dt + da2
      e_n3_in = (e_h <<< 3) + (e_h <<< 1) - (e_d <<< 3) + e_a;
      e_n4_in = (e_d <<< 4) - (e_d <<< 1) - ((e_h <<< 4) - e_h) - (e_a <<< 1);
      e_n5_in = (e_h <<< 2) + (e_h <<< 1) - (e_d <<< 2) - (e_d <<< 1) + e_a;
      e_t4_in = 96'(d_t4pp_ff[0]) + (96'(d_t4pp_ff[1]) << 32) + (96'(d_t4pp_ff[2]) << 64);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e_n3_ff <= e_n3_in;
         e_n4_ff <= e_n4_in;
         e_n5_ff <= e_n5_in;
         e_t4_ff <= e_t4_in;
         e_t3_ff <= d_t3_ff;
         e_t_ff  <= d_t_ff;
      end
   end

   // ---------------- stage f: T^5 partial products ----------------
   logic signed [W_N-1:0] f_n3_ff, f_n4_ff, f_n5_ff;
   logic        [95:0]    f_t4_ff;
   logic        [71:0]    f_t3_ff;
   logic        [55:0]    f_t5pp_in [0:2];
   logic        [55:0]    f_t5pp_ff [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         f_t5pp_in[k] = 56'(e_t4_ff[32*k +: 32]) * 56'(e_t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         f_n3_ff   <= e_n3_ff;
         f_n4_ff   <= e_n4_ff;
         f_n5_ff   <= e_n5_ff;
         f_t4_ff   <= e_t4_ff;
         f_t3_ff   <= e_t3_ff;
         f_t5pp_ff <= f_t5pp_in;
      end
   end

   // ---------------- stage g: T^5 ----------------
   logic signed [W_N-1:0] g_n3_ff, g_n4_ff, g_n5_ff;
   logic        [95:0]    g_t4_ff;
   logic        [71:0]    g_t3_ff;
   logic        [119:0]   g_t5_in, g_t5_ff;

   always_comb begin
      g_t5_in = 120'(f_t5pp_ff[0]) + (120'(f_t5pp_ff[1]) << 32)
              + (120'(f_t5pp_ff[2]) << 64);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         g_n3_ff <= f_n3_ff;
         g_n4_ff <= f_n4_ff;
         g_n5_ff <= f_n5_ff;
         g_t4_ff <= f_t4_ff;
         g_t3_ff <= f_t3_ff;
         g_t5_ff <= g_t5_in;
      end
   end

   // ---------------- dividers: divisor is twice the denominator 2 T^k ----------------
   logic signed [63:0] q3, q4, q5;
   logic               s3, s4, s5;

   qmjs_div #(.NUM_W(W_N), .DEN_W(74), .PW(O)) u_div3 (
      .clock (clock),
      .en    (pipe_en),
      .num   (g_n3_ff),
      .den   ({g_t3_ff, 2'b00}),
      .coef  (q3),
      .sat   (s3)
   );

   qmjs_div #(.NUM_W(W_N), .DEN_W(98), .PW(O + F)) u_div4 (
      .clock (clock),
      .en    (pipe_en),
      .num   (g_n4_ff),
      .den   ({g_t4_ff, 2'b00}),
      .coef  (q4),
      .sat   (s4)
   );

   qmjs_div #(.NUM_W(W_N), .DEN_W(122), .PW(O + 2 * F)) u_div5 (
      .clock (clock),
      .en    (pipe_en),
      .num   (g_n5_ff),
      .den   ({g_t5_ff, 2'b00}),
      .coef  (q5),
      .sat   (s5)
   );

   // ---------------- side data delay line ----------------
   qmjs_pkg::side_type side_ff [1:NV-1];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[1] <= side_in;
         for (int k = 2; k < NV; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- output register ----------------
   qmjs_pkg::side_type side_out;
   logic signed [63:0] rc0_ff, rc1_ff, rc2_ff, rc3_ff, rc4_ff, rc5_ff;
   logic signed [63:0] rc3_in, rc4_in, rc5_in;
   logic        [1:0]  rst_ff, rst_in;

   always_comb begin
      side_out = side_ff[NV-1];
      rc3_in   = side_out.zero ? '0 : q3;
      rc4_in   = side_out.zero ? '0 : q4;
      rc5_in   = side_out.zero ? '0 : q5;
      if (side_out.zero) begin
         rst_in = qmjs_pkg::ST_ZERO;
      end else if (side_out.sat | s3 | s4 | s5) begin
         rst_in = qmjs_pkg::ST_SAT;
      end else begin
         rst_in = qmjs_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rc0_ff <= side_out.c0;
         rc1_ff <= side_out.c1;
         rc2_ff <= side_out.c2;
         rc3_ff <= rc3_in;
         rc4_ff <= rc4_in;
         rc5_ff <= rc5_in;
         rst_ff <= rst_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_coef_0 = rc0_ff;
   assign rsp_coef_1 = rc1_ff;
   assign rsp_coef_2 = rc2_ff;
   assign rsp_coef_3 = rc3_ff;
   assign rsp_coef_4 = rc4_ff;
   assign rsp_coef_5 = rc5_ff;
   assign rsp_status = rst_ff;

   // ---------------- assertions ----------------
   a_zero_coefs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == qmjs_pkg::ST_ZERO) |->
         (rsp_coef_3 == '0 && rsp_coef_4 == '0 && rsp_coef_5 == '0))
      else $error("zero duration with nonzero upper coefficients");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled while output register empty");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline moved while frozen");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_vld) |=> rsp_valid)
      else $error("finished request not presented");

endmodule
